[design/hrtp_pkg.sv]
// ---------------------------------------------------------------------------
// hrtp_pkg
// Word types, result kinds, error codes and character codes for the hex ROM
// text parser.
// ---------------------------------------------------------------------------
package hrtp_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  entry_number;
    logic [15:0] byte_address;
    logic [7:0]  byte_value;
    logic [4:0]  comment_offset;
    logic [16:0] entry_start;
    logic [16:0] entry_length;
    logic [2:0]  error_code;
    logic [23:0] error_position;
    logic        end_of_run;
  } out_word_t;

  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_COMMENT = 3'd1;
  localparam logic [2:0] KIND_CLOSED  = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [2:0] ERR_UNEXPECTED = 3'd0;
  localparam logic [2:0] ERR_RANGE      = 3'd1;
  localparam logic [2:0] ERR_DEFINED    = 3'd2;
  localparam logic [2:0] ERR_FULL       = 3'd3;
  localparam logic [2:0] ERR_ODD        = 3'd4;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [23:0] POS_MAX = 24'hFFFFFF;

endpackage

[design/hex_rom_text_parser_top.sv]
// ---------------------------------------------------------------------------
// hex_rom_text_parser_top
// Parses "#index:comment" entries followed by hex digit pairs and emits data
// bytes, comment characters, entry summaries and a final status word.
//
//   channel | ports                          | word
//   --------+--------------------------------+-----------
//   input   | in_valid  in_stall  in_word    | in_word_t
//   output  | out_valid out_stall out_word   | out_word_t
//
// One character is decoded in the cycle it is accepted; its zero to three
// result words go into a three-slot output buffer, shown one per cycle
// while out_stall is low. A character with at most one result is accepted
// every cycle while out_stall is low; one with more results holds the input while the buffer drains.
// Reset clears parse state, defined flags and the buffer; no clearing pass.
// out_stall holds the current word; in_stall rises when the buffer is busy.
// ---------------------------------------------------------------------------
module hex_rom_text_parser_top #(
  parameter int ENTRIES       = 16,
  parameter int DATA_BYTES    = 65536,
  parameter int COMMENT_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hrtp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output hrtp_pkg::out_word_t out_word
);
  import hrtp_pkg::*;

  localparam int IW  = $clog2(ENTRIES + 1);
  localparam int EIW = $clog2(ENTRIES);
  localparam int WPW = $clog2(DATA_BYTES + 1);
  localparam int CCW = $clog2(COMMENT_BYTES);

  typedef enum logic [2:0] {
    MODE_PREAMBLE,
    MODE_INDEX,
    MODE_CFIRST,
    MODE_COMMENT,
    MODE_DATA
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic               prev_nl_r, prev_nl_nxt;
  logic [IW-1:0]      acc_r, acc_nxt;
  logic [CCW-1:0]     cc_r, cc_nxt;
  logic [3:0]         hi_r, hi_nxt;
  logic               pend_r, pend_nxt;
  logic [WPW-1:0]     wp_r, wp_nxt;
  logic [WPW-1:0]     start_r, start_nxt;
  logic [ENTRIES-1:0] def_r, def_nxt;
  logic [23:0]        pos_r, pos_nxt;
  logic               stop_r, stop_nxt;

  out_word_t          buf_r [3];
  logic [1:0]         cnt_r;
  out_word_t          res [3];
  logic [1:0]         n;

  logic               in_acc, out_acc;
  logic [7:0]         c;
  logic               is_dec, is_af, is_sp;
  logic [3:0]         dig;
  logic [IW+3:0]      acc_ext;
  logic [WPW-1:0]     len;
  logic [31:0]        acc32, wp32, start32, len32, cc32;

  assign out_valid = (cnt_r != 2'd0);
  assign out_word  = buf_r[0];
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_acc));
  assign in_acc    = in_valid && !in_stall;

  assign c      = in_word.ch;
  assign is_dec = (c >= "0") && (c <= "9");
  assign is_af  = (c >= "A") && (c <= "F");
  assign is_sp  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  assign dig    = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);

  always_comb begin
    mode_nxt    = mode_r;
    prev_nl_nxt = prev_nl_r;
    acc_nxt     = acc_r;
    cc_nxt      = cc_r;
    hi_nxt      = hi_r;
    pend_nxt    = pend_r;
    wp_nxt      = wp_r;
    start_nxt   = start_r;
    def_nxt     = def_r;
    pos_nxt     = pos_r;
    stop_nxt    = stop_r;
    n           = 2'd0;
    res[0]      = '0;
    res[1]      = '0;
    res[2]      = '0;
    acc_ext     = '0;
    len         = '0;
    acc32       = '0;
    wp32        = '0;
    start32     = '0;
    len32       = '0;
    cc32        = '0;

    if (!stop_r) begin
      pos_nxt = (pos_r == POS_MAX) ? pos_r : 24'(pos_r + 24'd1);
      acc32   = 32'(acc_r);
      cc32    = 32'(cc_r);
      wp32    = 32'(wp_r);

      unique case (mode_r)
        MODE_PREAMBLE: begin
          if ((c == CH_HASH) && prev_nl_r) begin
            mode_nxt = MODE_INDEX;
            acc_nxt  = '0;
          end
          prev_nl_nxt = (c == CH_LF);
        end
        MODE_INDEX: begin
          if (is_dec) begin
            acc_ext = (IW+4)'({4'd0, acc_r} << 3) + (IW+4)'({4'd0, acc_r} << 1)
                      + (IW+4)'(c[3:0]);
            acc_nxt = (acc_ext > (IW+4)'(ENTRIES)) ? IW'(ENTRIES) : acc_ext[IW-1:0];
          end else if (c == CH_COLON) begin
            if (acc_r >= IW'(ENTRIES)) begin
              res[n].kind           = KIND_ERROR;
              res[n].error_code     = ERR_RANGE;
              res[n].error_position = pos_nxt;
              n        = n + 2'd1;
              stop_nxt = 1'b1;
            end else if (def_r[acc_r[EIW-1:0]]) begin
              res[n].kind           = KIND_ERROR;
              res[n].error_code     = ERR_DEFINED;
              res[n].error_position = pos_nxt;
              n        = n + 2'd1;
              stop_nxt = 1'b1;
            end else begin
              start_nxt = wp_r;
              cc_nxt    = '0;
              pend_nxt  = 1'b0;
              hi_nxt    = '0;
              mode_nxt  = MODE_CFIRST;
            end
          end else begin
            res[n].kind           = KIND_ERROR;
            res[n].error_code     = ERR_UNEXPECTED;
            res[n].error_position = pos_r;
            n        = n + 2'd1;
            stop_nxt = 1'b1;
          end
        end
        MODE_CFIRST, MODE_COMMENT: begin
          if ((mode_r == MODE_COMMENT) && ((c == CH_LF) || (c == CH_CR))) begin
            mode_nxt = MODE_DATA;
          end else begin
            mode_nxt = MODE_COMMENT;
            if (cc_r < CCW'(COMMENT_BYTES - 1)) begin
              res[n].kind           = KIND_COMMENT;
              res[n].entry_number   = acc32[3:0];
              res[n].byte_value     = c;
              res[n].comment_offset = cc32[4:0];
              n      = n + 2'd1;
              cc_nxt = CCW'(cc_r + 1'b1);
            end
          end
        end
        MODE_DATA: begin
          if (is_dec || is_af) begin
            if (!pend_r) begin
              hi_nxt   = dig;
              pend_nxt = 1'b1;
            end else if (wp_r >= WPW'(DATA_BYTES)) begin
              res[n].kind           = KIND_ERROR;
              res[n].error_code     = ERR_FULL;
              res[n].error_position = pos_r;
              n        = n + 2'd1;
              stop_nxt = 1'b1;
            end else begin
              res[n].kind         = KIND_DATA;
              res[n].entry_number = acc32[3:0];
              res[n].byte_address = wp32[15:0];
              res[n].byte_value   = {hi_r, dig};
              n        = n + 2'd1;
              wp_nxt   = WPW'(wp_r + 1'b1);
              pend_nxt = 1'b0;
            end
          end else if (c == CH_HASH) begin
            if (pend_r) begin
              res[n].kind           = KIND_ERROR;
              res[n].error_code     = ERR_ODD;
              res[n].error_position = pos_r;
              n        = n + 2'd1;
              stop_nxt = 1'b1;
            end else begin
              len     = wp_r - start_r;
              start32 = 32'(start_r);
              len32   = 32'(len);
              res[n].kind         = KIND_CLOSED;
              res[n].entry_number = acc32[3:0];
              res[n].entry_start  = start32[16:0];
              res[n].entry_length = len32[16:0];
              n = n + 2'd1;
              if (len != '0) begin
                def_nxt[acc_r[EIW-1:0]] = 1'b1;
              end
              mode_nxt = MODE_INDEX;
              acc_nxt  = '0;
            end
          end else if (!is_sp) begin
            res[n].kind           = KIND_ERROR;
            res[n].error_code     = ERR_UNEXPECTED;
            res[n].error_position = pos_r;
            n        = n + 2'd1;
            stop_nxt = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_PREAMBLE;
        end
      endcase

      if (!stop_nxt && in_word.last) begin
        if (mode_nxt == MODE_PREAMBLE) begin
          res[n].kind = KIND_DONE;
          n = n + 2'd1;
        end else if (mode_nxt == MODE_INDEX) begin
          res[n].kind           = KIND_ERROR;
          res[n].error_code     = ERR_UNEXPECTED;
          res[n].error_position = pos_nxt;
          n = n + 2'd1;
        end else if (pend_nxt) begin
          res[n].kind           = KIND_ERROR;
          res[n].error_code     = ERR_ODD;
          res[n].error_position = pos_nxt;
          n = n + 2'd1;
        end else begin
          len     = wp_nxt - start_nxt;
          start32 = 32'(start_nxt);
          len32   = 32'(len);
          acc32   = 32'(acc_nxt);
          res[n].kind         = KIND_CLOSED;
          res[n].entry_number = acc32[3:0];
          res[n].entry_start  = start32[16:0];
          res[n].entry_length = len32[16:0];
          n = n + 2'd1;
          if ((len != '0) && (acc_nxt < IW'(ENTRIES))) begin
            def_nxt[acc_nxt[EIW-1:0]] = 1'b1;
          end
          res[n].kind = KIND_DONE;
          n = n + 2'd1;
        end
        stop_nxt = 1'b1;
      end

      if (n != 2'd0) begin
        res[2'(n - 2'd1)].end_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_PREAMBLE;
      prev_nl_r <= 1'b1;
      acc_r     <= '0;
      cc_r      <= '0;
      hi_r      <= '0;
      pend_r    <= 1'b0;
      wp_r      <= '0;
      start_r   <= '0;
      def_r     <= '0;
      pos_r     <= '0;
      stop_r    <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      if (in_acc) begin
        mode_r    <= mode_nxt;
        prev_nl_r <= prev_nl_nxt;
        acc_r     <= acc_nxt;
        cc_r      <= cc_nxt;
        hi_r      <= hi_nxt;
        pend_r    <= pend_nxt;
        wp_r      <= wp_nxt;
        start_r   <= start_nxt;
        def_r     <= def_nxt;
        pos_r     <= pos_nxt;
        stop_r    <= stop_nxt;
        cnt_r     <= n;
      end else if (out_acc) begin
        cnt_r <= 2'(cnt_r - 2'd1);
      end
    end
  end

  // result buffer payload; slot 0 is presented
  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_r[0] <= res[0];
      buf_r[1] <= res[1];
      buf_r[2] <= res[2];
    end else if (out_acc) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
    end
  end

endmodule
